>>> sv/siphash_pkg.sv
// shared types, constants and the round function of the keyed hash engine
package siphash_pkg;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned ROUND_W    = 4;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_C_ROUNDS  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_F_ROUNDS  = 8'd3;

  localparam logic [ROUND_W-1:0] C_ROUNDS_RST = 4'd2;
  localparam logic [ROUND_W-1:0] F_ROUNDS_RST = 4'd4;

  localparam logic [63:0] INIT_A     = 64'h736f6d6570736575;
  localparam logic [63:0] INIT_B     = 64'h646f72616e646f6d;
  localparam logic [63:0] INIT_C     = 64'h6c7967656e657261;
  localparam logic [63:0] INIT_D     = 64'h7465646279746573;
  localparam logic [63:0] FINAL_MARK = 64'h00000000000000ff;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
  } sip_state_t;

  // controller to datapath
  typedef struct packed {
    logic take;        // beat accepted: pack byte, maybe start a word
    logic load_final;  // build closing word and xor it into d
    logic round;       // one sipround
    logic finish;      // xor word into a
    logic mark;        // xor final mark into c
    logic emit;        // digest to output register, restart lanes
  } sip_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full_word;   // the offered byte completes a word
    logic out_free;    // output register can take a digest this cycle
  } sip_stat_t;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
    rotl = (x << r) | (x >> (64 - r));
  endfunction

  function automatic sip_state_t sip_init(input logic [63:0] klo, input logic [63:0] khi);
    sip_state_t s;
    s.a = klo ^ INIT_A;
    s.b = khi ^ INIT_B;
    s.c = klo ^ INIT_C;
    s.d = khi ^ INIT_D;
    sip_init = s;
  endfunction

  function automatic sip_state_t sip_round(input sip_state_t s);
    sip_state_t t;
    t = s;
    t.a = t.a + t.b;
    t.c = t.c + t.d;
    t.b = rotl(t.b, 13) ^ t.a;
    t.d = rotl(t.d, 16) ^ t.c;
    t.a = rotl(t.a, 32);
    t.c = t.c + t.b;
    t.a = t.a + t.d;
    t.b = rotl(t.b, 17) ^ t.c;
    t.d = rotl(t.d, 21) ^ t.a;
    t.c = rotl(t.c, 32);
    sip_round = t;
  endfunction

endpackage

>>> sv/siphash_if.sv
// valid/ready channels for message bytes and digests

interface siphash_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last_byte;

  modport source (output valid, data_byte, has_byte, last_byte, input ready);
  modport sink (input valid, data_byte, has_byte, last_byte, output ready);
endinterface

interface siphash_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest;

  modport source (output valid, digest, input ready);
  modport sink (input valid, digest, output ready);
endinterface

>>> sv/siphash_dp.sv
// datapath: lanes, word packing, round unit and digest output register
module siphash_dp
  import siphash_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [7:0]            data_byte,
  input  logic                  has_byte,
  input  sip_cmd_t              cmd,
  output sip_stat_t             stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [63:0]           digest
);

  logic [63:0] key_low;
  logic [63:0] key_high;
  sip_state_t  lanes;
  logic [63:0] acc;
  logic [2:0]  pos;
  logic [7:0]  len;
  logic [63:0] word;

  logic [63:0] acc_next;
  logic [63:0] final_word;
  logic        key_wr_low;
  logic        key_wr_high;

  always_comb begin
    acc_next   = acc | ({56'd0, data_byte} << {pos, 3'b000});
    final_word = acc | {len, 56'd0};
    key_wr_low  = cfg_we && (cfg_index == REG_KEY_LOW);
    key_wr_high = cfg_we && (cfg_index == REG_KEY_HIGH);
    stat.full_word = has_byte && (pos == 3'd7);
    stat.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low   <= '0;
      key_high  <= '0;
      lanes     <= sip_init('0, '0);
      acc       <= '0;
      pos       <= '0;
      len       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (key_wr_low || key_wr_high) begin
        // a new key drops any partly received message
        if (key_wr_low) begin
          key_low <= cfg_data;
        end
        if (key_wr_high) begin
          key_high <= cfg_data;
        end
        lanes <= sip_init(key_wr_low ? cfg_data : key_low, key_wr_high ? cfg_data : key_high);
        acc   <= '0;
        pos   <= '0;
        len   <= '0;
      end else if (cmd.take) begin
        if (has_byte) begin
          len <= len + 8'd1;
          if (pos == 3'd7) begin
            word    <= acc_next;
            lanes.d <= lanes.d ^ acc_next;
            acc     <= '0;
            pos     <= '0;
          end else begin
            acc <= acc_next;
            pos <= pos + 3'd1;
          end
        end
      end else if (cmd.load_final) begin
        word    <= final_word;
        lanes.d <= lanes.d ^ final_word;
      end else if (cmd.round) begin
        lanes <= sip_round(lanes);
      end else if (cmd.finish) begin
        lanes.a <= lanes.a ^ word;
        if (cmd.mark) begin
          lanes.c <= lanes.c ^ FINAL_MARK;
        end
      end else if (cmd.emit) begin
        lanes <= sip_init(key_low, key_high);
        acc   <= '0;
        pos   <= '0;
        len   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      digest <= lanes.a ^ lanes.b ^ lanes.c ^ lanes.d;
    end
  end

endmodule

>>> sv/siphash_ctrl.sv
// controller: sequences absorb, round and finalization steps
module siphash_ctrl
  import siphash_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_last,
  output logic                  in_ready,
  input  sip_stat_t             stat,
  output sip_cmd_t              cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CROUNDS = 3'd1;
  localparam logic [2:0] S_LOADF   = 3'd2;
  localparam logic [2:0] S_FROUNDS = 3'd3;
  localparam logic [2:0] S_EMIT    = 3'd4;

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic [ROUND_W-1:0] cnt;
  logic [ROUND_W-1:0] cnt_next;
  logic [ROUND_W-1:0] c_rounds;
  logic [ROUND_W-1:0] f_rounds;
  logic               pend_last;
  logic               pend_last_next;
  logic               is_final;
  logic               is_final_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd            = '0;
    state_next     = state;
    cnt_next       = cnt;
    pend_last_next = pend_last;
    is_final_next  = is_final;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (stat.full_word) begin
            cnt_next       = c_rounds;
            pend_last_next = in_last;
            is_final_next  = 1'b0;
            state_next     = S_CROUNDS;
          end else if (in_last) begin
            state_next = S_LOADF;
          end
        end
      end
      S_CROUNDS: begin
        if (cnt != '0) begin
          cmd.round = 1'b1;
          cnt_next  = cnt - 1'b1;
        end else begin
          cmd.finish = 1'b1;
          if (is_final) begin
            cmd.mark   = 1'b1;
            cnt_next   = f_rounds;
            state_next = S_FROUNDS;
          end else if (pend_last) begin
            state_next = S_LOADF;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_LOADF: begin
        cmd.load_final = 1'b1;
        cnt_next       = c_rounds;
        is_final_next  = 1'b1;
        pend_last_next = 1'b0;
        state_next     = S_CROUNDS;
      end
      S_FROUNDS: begin
        if (cnt != '0) begin
          cmd.round = 1'b1;
          cnt_next  = cnt - 1'b1;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          is_final_next = 1'b0;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      pend_last <= 1'b0;
      is_final  <= 1'b0;
      c_rounds  <= C_ROUNDS_RST;
      f_rounds  <= F_ROUNDS_RST;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      pend_last <= pend_last_next;
      is_final  <= is_final_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_C_ROUNDS: c_rounds <= cfg_data[ROUND_W-1:0];
          REG_F_ROUNDS: f_rounds <= cfg_data[ROUND_W-1:0];
          default: ;
        endcase
      end
    end
  end

  a_full_word_rounds: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && stat.full_word) |=> (state == S_CROUNDS))
    else $error("full word did not start compression rounds");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("digest written over a waiting result");

  a_final_mark: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && is_final) |=> (state == S_FROUNDS))
    else $error("closing word absorbed without finalization");

  a_rounds_end_emit: assert property (@(posedge clk) disable iff (rst)
    (state == S_FROUNDS && cnt == '0) |=> (state == S_EMIT))
    else $error("finalization did not end in emit");

endmodule

>>> sv/siphash_keyed_hash.sv
// top level of the keyed 64-bit hash engine
//
//   channel | dir | fields                           | one beat
//   msg     | in  | data_byte, has_byte, last_byte   | one message byte or close mark
//   res     | out | digest                           | hash of one closed message
//   cfg     | in  | cfg_we, cfg_index, cfg_data      | one register write
//
// a byte that does not complete a word is only packed
// a completed word is taken, runs c rounds (one sipround per cycle on the shared round unit) and is xored into a
// a closing beat then adds these steps: closing word, c rounds, mark, d rounds,
// final count check, emit
// reset gives key zero, c = 2, d = 4; a key write drops a partly received message
// the output register lets new bytes enter while a digest waits; only the next
// emit stalls until res takes it
module siphash_keyed_hash
  import siphash_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  siphash_msg_if.sink           msg,
  siphash_res_if.source         res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  sip_cmd_t  cmd;
  sip_stat_t stat;
  logic      in_ready;

  assign msg.ready = in_ready;

  siphash_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (msg.valid),
    .in_last   (msg.last_byte),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  siphash_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .data_byte (msg.data_byte),
    .has_byte  (msg.has_byte),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .digest    (res.digest)
  );

endmodule

>>> tb/siphash_keyed_hash_tb.sv
// self-checking testbench for the keyed 64-bit hash engine with its own digest predictor
module siphash_keyed_hash_tb
  import siphash_pkg::*;
();

  localparam int SETTLE_CYCLES = 48;
  localparam int PHASE_BEATS   = 150;
  localparam int CLOSE_NONE      = 0;
  localparam int CLOSE_ON_BYTE   = 1;
  localparam int CLOSE_SEPARATE  = 2;

  typedef enum logic [1:0] {EV_BEAT, EV_REG, EV_PACE} stim_kind_t;

  typedef struct {
    stim_kind_t            kind;
    logic [7:0]            data_byte;
    logic                  has_byte;
    logic                  last_byte;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    int                    send_gap;
    int                    recv_gap;
  } stim_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  siphash_msg_if msg ();
  siphash_res_if res ();

  siphash_keyed_hash u_top (
    .clk       (clk),
    .rst       (rst),
    .msg       (msg),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  stim_t       pending[$];
  logic [63:0] digests_due[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet = 0;
  int fail_count = 0;
  int beats_queued = 0;
  bit msg_busy = 1'b0;
  bit beat_went = 1'b0;

  // predictor state
  bit [63:0] key_lo_m;
  bit [63:0] key_hi_m;
  bit [3:0]  c_rounds_m;
  bit [3:0]  f_rounds_m;
  bit [63:0] h0, h1, h2, h3;
  bit [63:0] acc;
  int        pos;
  bit [7:0]  msg_len;

  int pace_send[4] = '{0, 60, 0, 17};
  int pace_recv[4] = '{0, 0, 60, 17};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit [63:0] rol64(bit [63:0] x, int r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic void mix_lanes();
    h0 = h0 + h1;
    h2 = h2 + h3;
    h1 = rol64(h1, 13) ^ h0;
    h3 = rol64(h3, 16) ^ h2;
    h0 = rol64(h0, 32);
    h2 = h2 + h1;
    h0 = h0 + h3;
    h1 = rol64(h1, 17) ^ h2;
    h3 = rol64(h3, 21) ^ h0;
    h2 = rol64(h2, 32);
  endfunction

  function automatic void absorb_word(bit [63:0] m);
    h3 = h3 ^ m;
    repeat (c_rounds_m) mix_lanes();
    h0 = h0 ^ m;
  endfunction

  function automatic void reload_lanes();
    h0 = key_lo_m ^ INIT_A;
    h1 = key_hi_m ^ INIT_B;
    h2 = key_lo_m ^ INIT_C;
    h3 = key_hi_m ^ INIT_D;
    acc = '0;
    pos = 0;
    msg_len = '0;
  endfunction

  function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_KEY_LOW: begin
        key_lo_m = val;
        reload_lanes();
      end
      REG_KEY_HIGH: begin
        key_hi_m = val;
        reload_lanes();
      end
      REG_C_ROUNDS: c_rounds_m = val[ROUND_W-1:0];
      REG_F_ROUNDS: f_rounds_m = val[ROUND_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void hash_beat(logic [7:0] d, logic has, logic last);
    if (has) begin
      acc = acc | ({56'd0, d} << (8 * pos));
      msg_len = msg_len + 8'd1;
      pos = pos + 1;
      if (pos == 8) begin
        absorb_word(acc);
        acc = '0;
        pos = 0;
      end
    end
    if (last) begin
      absorb_word(acc | {msg_len, 56'd0});
      h2 = h2 ^ FINAL_MARK;
      repeat (f_rounds_m) mix_lanes();
      digests_due.push_back(h0 ^ h1 ^ h2 ^ h3);
      reload_lanes();
    end
  endfunction

  task automatic add_beat(logic [7:0] d, logic has, logic last);
    stim_t s;
    s = '{kind: EV_BEAT, data_byte: d, has_byte: has, last_byte: last,
          reg_idx: '0, reg_val: '0, send_gap: 0, recv_gap: 0};
    pending.push_back(s);
    if (has || last) beats_queued++;
  endtask

  task automatic add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    stim_t s;
    s = '{kind: EV_REG, data_byte: '0, has_byte: 1'b0, last_byte: 1'b0,
          reg_idx: idx, reg_val: val, send_gap: 0, recv_gap: 0};
    pending.push_back(s);
  endtask

  task automatic add_pace(int send_pct, int recv_pct);
    stim_t s;
    s = '{kind: EV_PACE, data_byte: '0, has_byte: 1'b0, last_byte: 1'b0,
          reg_idx: '0, reg_val: '0, send_gap: send_pct, recv_gap: recv_pct};
    pending.push_back(s);
  endtask

  // random bytes with the odd ignored beat mixed in
  task automatic add_message(int n_bytes, int close_mode);
    for (int i = 0; i < n_bytes; i++) begin
      if ($urandom_range(99) < 8) add_beat(8'($urandom), 1'b0, 1'b0);
      add_beat(8'($urandom), 1'b1, close_mode == CLOSE_ON_BYTE && i == n_bytes - 1);
    end
    if (close_mode == CLOSE_SEPARATE || (close_mode == CLOSE_ON_BYTE && n_bytes == 0))
      add_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic flag_digest(string why, logic [63:0] want, logic [63:0] got);
    fail_count++;
    if (fail_count <= 10) $display("digest %s: expected %h, got %h", why, want, got);
  endtask

  always @(negedge clk) begin : drive
    stim_t head;
    logic  we_next;
    if (!rst) begin
      if (beat_went) begin
        msg_busy = 1'b0;
        beat_went = 1'b0;
      end
      we_next = 1'b0;
      while (pending.size() > 0 && pending[0].kind == EV_PACE) begin
        head = pending.pop_front();
        send_idle_pct = head.send_gap;
        recv_stall_pct = head.recv_gap;
      end
      if (!msg_busy && pending.size() > 0) begin
        head = pending[0];
        if (head.kind == EV_REG) begin
          // registers only change once the engine has drained
          if (digests_due.size() == 0 && quiet >= SETTLE_CYCLES) begin
            head = pending.pop_front();
            we_next = 1'b1;
            cfg_index <= head.reg_idx;
            cfg_data <= head.reg_val;
          end
        end else if ($urandom_range(99) >= send_idle_pct) begin
          head = pending.pop_front();
          msg_busy = 1'b1;
          msg.data_byte <= head.data_byte;
          msg.has_byte <= head.has_byte;
          msg.last_byte <= head.last_byte;
        end
      end
      msg.valid <= msg_busy;
      cfg_we <= we_next;
      res.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : observe
    logic [63:0] want;
    if (!rst) begin
      if (res.valid && res.ready) begin
        quiet = 0;
        if (digests_due.size() == 0) begin
          flag_digest("with nothing pending", 'x, res.digest);
        end else begin
          want = digests_due.pop_front();
          if (res.digest !== want) flag_digest("mismatch", want, res.digest);
        end
      end else if (!(msg.valid && msg.ready)) begin
        quiet++;
      end
      if (cfg_we) apply_reg_write(cfg_index, cfg_data);
      if (msg.valid && msg.ready) begin
        quiet = 0;
        beat_went = 1'b1;
        hash_beat(msg.data_byte, msg.has_byte, msg.last_byte);
      end
    end
  end

  initial begin
    #(4 * 600000);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int          target;
    int          cr, fr;
    logic [63:0] klo, khi;
    clk = 1'b0;
    rst = 1'b1;
    msg.valid = 1'b0;
    msg.data_byte = '0;
    msg.has_byte = 1'b0;
    msg.last_byte = 1'b0;
    res.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;

    key_lo_m = '0;
    key_hi_m = '0;
    c_rounds_m = C_ROUNDS_RST;
    f_rounds_m = F_ROUNDS_RST;
    reload_lanes();

    // directed: reset settings, empty message, ignored beat, word edges
    add_pace(0, 0);
    add_beat(8'h00, 1'b0, 1'b1);
    add_beat(8'hff, 1'b0, 1'b0);
    add_message(3, CLOSE_ON_BYTE);
    for (int i = 0; i < 8; i++) add_beat(8'hff, 1'b1, i == 7);
    for (int i = 0; i < 8; i++) add_beat(8'h00, 1'b1, 1'b0);
    add_beat(8'h00, 1'b0, 1'b1);

    for (int ph = 0; ph < 8; ph++) begin
      add_pace(pace_send[ph % 4], pace_recv[ph % 4]);
      // a partial message: dropped by a key write, kept across round writes
      if (ph % 2 == 1) add_message($urandom_range(13, 1), CLOSE_NONE);
      case (ph)
        0: begin cr = 0;  fr = 0;  end
        1: begin cr = 15; fr = 15; end
        2: begin cr = 1;  fr = 0;  end
        3: begin cr = 0;  fr = 15; end
        default: begin
          cr = $urandom_range(15);
          fr = $urandom_range(15);
        end
      endcase
      case (ph)
        1: begin klo = '1; khi = '1; end
        2: begin klo = '0; khi = '0; end
        3: begin klo = '1; khi = '0; end
        default: begin
          klo = {$urandom, $urandom};
          khi = {$urandom, $urandom};
        end
      endcase
      add_reg(REG_C_ROUNDS, {$urandom, $urandom} & ~64'hf | 64'(cr));
      if (ph != 5) begin
        add_reg(REG_KEY_LOW, klo);
        add_reg(REG_KEY_HIGH, khi);
      end
      add_reg(REG_F_ROUNDS, {$urandom, $urandom} & ~64'hf | 64'(fr));
      add_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, REG_F_ROUNDS + 1)),
              {$urandom, $urandom});

      target = beats_queued + PHASE_BEATS;
      // length byte wraps past 255
      if (ph == 3) add_message(300, CLOSE_SEPARATE);
      while (beats_queued < target) begin
        int r;
        int n;
        r = $urandom_range(99);
        if (r < 5)       n = 0;
        else if (r < 80) n = $urandom_range(16, 1);
        else if (r < 97) n = $urandom_range(64, 17);
        else             n = $urandom_range(280, 65);
        add_message(n, $urandom_range(1) ? CLOSE_ON_BYTE : CLOSE_SEPARATE);
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (!(pending.size() == 0 && !msg_busy && digests_due.size() == 0)) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && digests_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
